/* rtl/core/cht_pkg.sv */
// Package for the chained hash table unit: item structs, memory word
// layouts, operation and status codes, and the controller state type.
// No dependencies.
package cht_pkg;

	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int LINK_W   = 7;
	localparam int TOTAL_W  = 7;

	localparam int DEF_NUM_BUCKETS  = 16;
	localparam int DEF_POOL_ENTRIES = 64;

	// Link value that names no entry.
	localparam logic [LINK_W-1:0] NULL_LINK = 7'd64;

	localparam logic [KEY_W-1:0] HASH_MULT = 32'h045d9f3b;

	// Bucket reduction by a non power of two count: bits per cycle, number of steps.
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = KEY_W / MOD_BITS;
	localparam int STEP_W    = $clog2(MOD_STEPS);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUT  = 2'd0,
		MODE_GET  = 2'd1,
		MODE_LIST = 2'd2
	} cht_mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} cht_status_t;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} cht_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic                    found;
		logic signed [VAL_W-1:0] result_value;
		logic signed [KEY_W-1:0] result_key;
		logic [TOTAL_W-1:0]      entry_total;
		logic                    last;
	} cht_out_t;

	typedef struct packed {
		logic [LINK_W-1:0] head;
		logic [LINK_W-1:0] tail;
	} cht_bkt_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [LINK_W-1:0] link;
	} cht_ent_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_MOD,
		ST_BRD,
		ST_BCHK,
		ST_ECHK,
		ST_UPD,
		ST_LINK,
		ST_INS,
		ST_RESP,
		ST_LBRD,
		ST_LBCHK,
		ST_LECHK
	} cht_state_t;

endpackage

/* rtl/core/chained_hash_table_unit.sv */
// Top level of the chained hash table unit: controller, hash datapath,
// bucket memory and entry memory. Depends on cht_pkg.
//
// Integer key/value map with separate chaining over a pool of POOL_ENTRIES
// entries spread over NUM_BUCKETS buckets. Each input item is one operation:
// put (insert or update), get, or list (one result item per stored key, in
// bucket order and then chain order, the final one marked by last; an empty
// table gives one item with status not-found). Mode three is consumed and
// gives no result. The block works on one item at a time. After reset a
// clearing pass writes null links into the bucket memory; in_ready stays
// low until it ends. Put and get go through the hash multiplier, bucket
// read and the entry walk (one entry memory read a cycle); a put then
// updates in place, or inserts if the pool has room, first linking the
// chain's last entry when the chain is not empty. When NUM_BUCKETS is not a
// power of two, a bucket reduction (4 remainder bits a cycle) comes
// before the bucket read. List reads the buckets in order and walks each
// chain that holds keys.
// Result items leave through an output register, so a stalled consumer only
// holds the block at the point where it has a result to hand over.
module chained_hash_table_unit #(
	parameter int NUM_BUCKETS  = cht_pkg::DEF_NUM_BUCKETS,
	parameter int POOL_ENTRIES = cht_pkg::DEF_POOL_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cht_pkg::cht_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cht_pkg::cht_out_t out_item
);
	import cht_pkg::*;

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ENT_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int REM_W = BKT_W + 1;
	localparam bit BKT_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
	localparam logic [BKT_W-1:0]   BKT_MASK = BKT_W'(NUM_BUCKETS - 1);
	localparam logic [BKT_W-1:0]   BKT_LAST = BKT_W'(NUM_BUCKETS - 1);
	localparam logic [REM_W-1:0]   BKT_DIV  = REM_W'(NUM_BUCKETS);
	localparam logic [LINK_W-1:0]  POOL_CAP = LINK_W'(POOL_ENTRIES);
	localparam logic [STEP_W-1:0]  STEP_END = STEP_W'(MOD_STEPS - 1);

	// Controller state
	cht_state_t state_q, state_d;

	// Operation registers
	logic [MODE_W-1:0]  mode_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [KEY_W-1:0]   prod_q;
	logic [KEY_W-1:0]   mag_q;
	logic [REM_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [BKT_W-1:0]   bkt_q;
	logic [LINK_W-1:0]  p_q;
	logic [LINK_W-1:0]  count_q;
	logic [LINK_W-1:0]  emit_q;
	cht_out_t           res_q;

	// Output register
	logic     out_valid_q;
	cht_out_t out_q;

	// Memories and their ports
	cht_bkt_t bkt_mem [NUM_BUCKETS];
	cht_ent_t ent_mem [POOL_ENTRIES];
	cht_bkt_t bkt_rd_q;
	cht_ent_t ent_rd_q;

	logic              bkt_re, bkt_we;
	logic [BKT_W-1:0]  bkt_addr;
	cht_bkt_t          bkt_wdata;
	logic              ent_re, ent_we;
	logic [LINK_W-1:0] ent_rlink;
	logic [ENT_W-1:0]  ent_waddr;
	cht_ent_t          ent_wdata;

	// Datapath helpers
	logic [2*KEY_W-1:0] mul_full;
	logic [KEY_W-1:0]   mix;
	logic [KEY_W-1:0]   fold;
	logic [KEY_W-1:0]   mag_d;
	logic [REM_W-1:0]   rem_d;
	logic               head_ok, tail_ok, next_ok, key_hit, pool_full;
	logic               out_free, list_last, chain_live;
	logic               out_load, res_load;
	cht_out_t           out_d, res_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Hash: xor-shift, multiply, xor-shift, magnitude.
	assign mix      = KEY_W'($signed(key_q) >>> 16) ^ key_q;
	assign mul_full = {{KEY_W{1'b0}}, mix} * {{KEY_W{1'b0}}, HASH_MULT};
	assign fold     = prod_q ^ (prod_q >> 16);
	assign mag_d    = fold[KEY_W-1] ? (~fold + KEY_W'(1)) : fold;

	// Restoring remainder, MOD_BITS quotient bits a cycle from the top.
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			r = {r[REM_W-2:0], mag_q[KEY_W-1-i]};
			if (r >= BKT_DIV)
				r = r - BKT_DIV;
		end
		rem_d = r;
	end

	// A link is live only if it names an allocated entry.
	assign head_ok    = bkt_rd_q.head < count_q;
	assign tail_ok    = bkt_rd_q.tail < count_q;
	assign next_ok    = ent_rd_q.link < count_q;
	assign chain_live = head_ok && tail_ok;
	assign key_hit    = ent_rd_q.key == key_q;
	assign pool_full  = count_q >= POOL_CAP;
	assign list_last  = (emit_q + LINK_W'(1)) == count_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (bkt_q == BKT_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.mode == MODE_PUT || in_item.mode == MODE_GET)
						state_d = ST_MUL;
					else if (in_item.mode == MODE_LIST)
						state_d = (count_q == '0) ? ST_RESP : ST_LBRD;
				end
			end
			ST_MUL:  state_d = ST_FOLD;
			ST_FOLD: state_d = BKT_POW2 ? ST_BRD : ST_MOD;
			ST_MOD: begin
				if (step_q == STEP_END)
					state_d = ST_BRD;
			end
			ST_BRD: state_d = ST_BCHK;
			ST_BCHK: begin
				if (head_ok)
					state_d = ST_ECHK;
				else if (mode_q == MODE_PUT && !pool_full)
					state_d = ST_INS;
				else
					state_d = ST_RESP;
			end
			ST_ECHK: begin
				if (key_hit)
					state_d = (mode_q == MODE_PUT) ? ST_UPD : ST_RESP;
				else if (next_ok)
					state_d = ST_ECHK;
				else if (mode_q == MODE_PUT && !pool_full)
					state_d = chain_live ? ST_LINK : ST_INS;
				else
					state_d = ST_RESP;
			end
			ST_UPD:  state_d = ST_RESP;
			ST_LINK: state_d = ST_INS;
			ST_INS:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			ST_LBRD: state_d = ST_LBCHK;
			ST_LBCHK: state_d = head_ok ? ST_LECHK : ST_LBRD;
			ST_LECHK: begin
				if (out_free) begin
					if (list_last)
						state_d = ST_IDLE;
					else if (!next_ok)
						state_d = ST_LBRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls, result staging and output loads
	always_comb begin
		bkt_re    = 1'b0;
		bkt_we    = 1'b0;
		bkt_addr  = bkt_q;
		bkt_wdata = '{head: NULL_LINK, tail: NULL_LINK};
		ent_re    = 1'b0;
		ent_rlink = ent_rd_q.link;
		ent_we    = 1'b0;
		ent_waddr = count_q[ENT_W-1:0];
		ent_wdata = '{key: key_q, value: val_q, link: NULL_LINK};
		res_load  = 1'b0;
		res_d     = '0;
		out_load  = 1'b0;
		out_d     = res_q;
		out_d.entry_total = count_q;
		out_d.last        = 1'b1;
		unique case (state_q)
			ST_CLEAR: bkt_we = 1'b1;
			ST_IDLE: begin
				// Empty table: one not-found item for a list request.
				res_load     = 1'b1;
				res_d.status = STAT_MISS;
			end
			ST_BRD, ST_LBRD: bkt_re = 1'b1;
			ST_BCHK: begin
				ent_re    = head_ok;
				ent_rlink = bkt_rd_q.head;
				if (!head_ok) begin
					res_load     = 1'b1;
					res_d.status = (mode_q == MODE_GET) ? STAT_MISS
						: (pool_full ? STAT_FULL : STAT_OK);
				end
			end
			ST_ECHK: begin
				ent_re   = !key_hit && next_ok;
				res_load = key_hit || !next_ok;
				if (key_hit) begin
					res_d.status = STAT_OK;
					res_d.found  = 1'b1;
					if (mode_q == MODE_GET)
						res_d.result_value = ent_rd_q.value;
				end else begin
					res_d.status = (mode_q == MODE_GET) ? STAT_MISS
						: (pool_full ? STAT_FULL : STAT_OK);
				end
			end
			ST_UPD: begin
				ent_we    = 1'b1;
				ent_waddr = p_q[ENT_W-1:0];
				ent_wdata = '{key: ent_rd_q.key, value: val_q, link: ent_rd_q.link};
			end
			ST_LINK: begin
				// Hook the new entry behind the chain's tail (last entry walked).
				ent_we    = 1'b1;
				ent_waddr = p_q[ENT_W-1:0];
				ent_wdata = '{key: ent_rd_q.key, value: ent_rd_q.value, link: count_q};
			end
			ST_INS: begin
				ent_we    = 1'b1;
				bkt_we    = 1'b1;
				bkt_wdata = '{head: chain_live ? bkt_rd_q.head : count_q, tail: count_q};
			end
			ST_RESP: out_load = out_free;
			ST_LBCHK: begin
				ent_re    = head_ok;
				ent_rlink = bkt_rd_q.head;
			end
			ST_LECHK: begin
				out_load           = out_free;
				out_d              = '0;
				out_d.status       = STAT_OK;
				out_d.result_key   = ent_rd_q.key;
				out_d.entry_total  = count_q;
				out_d.last         = list_last;
				ent_re             = out_free && !list_last && next_ok;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= '0;
			bkt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INS)
				count_q <= count_q + LINK_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: bkt_q <= bkt_q + BKT_W'(1);
				ST_IDLE:  bkt_q <= '0;
				ST_FOLD: begin
					step_q <= '0;
					if (BKT_POW2)
						bkt_q <= mag_d[BKT_W-1:0] & BKT_MASK;
				end
				ST_MOD: begin
					step_q <= step_q + STEP_W'(1);
					bkt_q  <= rem_d[BKT_W-1:0];
				end
				ST_LBCHK: begin
					if (!head_ok)
						bkt_q <= bkt_q + BKT_W'(1);
				end
				ST_LECHK: begin
					// Chain done: advance to the next bucket.
					if (out_free && !list_last && !next_ok)
						bkt_q <= bkt_q + BKT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= in_item.mode;
			key_q  <= in_item.key;
			val_q  <= in_item.value;
			emit_q <= '0;
		end
		if (state_q == ST_MUL)
			prod_q <= mul_full[KEY_W-1:0];
		if (state_q == ST_FOLD) begin
			mag_q <= mag_d;
			rem_q <= '0;
		end
		if (state_q == ST_MOD) begin
			mag_q <= mag_q << MOD_BITS;
			rem_q <= rem_d;
		end
		if (ent_re)
			p_q <= ent_rlink;
		if (state_q == ST_LECHK && out_free)
			emit_q <= emit_q + LINK_W'(1);
		if (res_load)
			res_q <= res_d;
		if (out_load)
			out_q <= out_d;
	end

	// Bucket memory: head and tail links per bucket. Reads and writes never
	// target the same entry in overlapping cycles: one item is in flight and
	// its writes finish before the next read is issued.
	always_ff @(posedge clk) begin
		if (bkt_we)
			bkt_mem[bkt_addr] <= bkt_wdata;
		if (bkt_re)
			bkt_rd_q <= bkt_mem[bkt_addr];
	end

	// Entry memory: key, value and chain link per pool slot.
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_waddr] <= ent_wdata;
		if (ent_re)
			ent_rd_q <= ent_mem[ent_rlink[ENT_W-1:0]];
	end

endmodule

/* rtl/core/cht_checker.sv */
// Port-level checks for the chained hash table unit, bound to its top level.
// Depends on cht_pkg and chained_hash_table_unit.
module cht_checker #(
	parameter int POOL_ENTRIES = cht_pkg::DEF_POOL_ENTRIES
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input cht_pkg::cht_out_t out_item
);
	import cht_pkg::*;

	localparam logic [TOTAL_W-1:0] POOL_CAP = TOTAL_W'(POOL_ENTRIES);

	// Hold a stalled result item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.entry_total <= POOL_CAP)
		else $error("entry total beyond pool size");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == STAT_FULL |->
			out_item.entry_total == POOL_CAP && !out_item.found && out_item.last)
		else $error("table full reported with free entries");

	a_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != STAT_OK |->
			out_item.last && out_item.result_value == '0 && out_item.result_key == '0)
		else $error("failing result item carries data");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.found |->
			out_item.status == STAT_OK && out_item.result_key == '0 && out_item.last)
		else $error("found flag on a list or failing item");

endmodule

bind chained_hash_table_unit cht_checker #(
	.POOL_ENTRIES(POOL_ENTRIES)
) u_cht_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);

/* tb/chained_hash_table_unit_test.sv */
// Self-checking bench for chained_hash_table_unit: put, get and list items
// are checked against a behavioral hash map kept inside the bench.
// Depends on cht_pkg and the unit's RTL.
module chained_hash_table_unit_test;

	import cht_pkg::*;

	localparam int NB          = DEF_NUM_BUCKETS;
	localparam int POOL        = DEF_POOL_ENTRIES;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 300;
	localparam int MAX_PRINTS  = 40;

	// Mode three has no name in the package; the unit swallows it silently.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		cht_in_t op;
		bit      wait_drain;   // hold this item until every reply is back
		bit      calm;         // no idling on either side from here on
	} queued_op_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	cht_in_t  in_item   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	cht_out_t out_item;

	queued_op_t op_queue[$];
	cht_out_t   table_replies[$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;

	// Shadow copy of the map: bucket links, entry pool and fill level.
	logic [LINK_W-1:0] head_mem [NB];
	logic [LINK_W-1:0] tail_mem [NB];
	logic [KEY_W-1:0]  key_mem  [POOL];
	logic [VAL_W-1:0]  val_mem  [POOL];
	logic [LINK_W-1:0] next_mem [POOL];
	int unsigned       used_entries;

	// Sender and receiver pacing.
	int unsigned gap_left    = 0;
	int unsigned tx_stretch  = 0;
	bit          tx_noisy    = 1'b1;
	bit          calm_run    = 1'b0;
	int unsigned stall_left  = 0;
	int unsigned rx_stretch  = 0;
	bit          rx_noisy    = 1'b1;

	// Keys the stimulus believes are stored, in insertion order.
	logic [KEY_W-1:0] gen_keys[$];
	bit               gen_calm = 1'b0;

	chained_hash_table_unit #(
		.NUM_BUCKETS (NB),
		.POOL_ENTRIES(POOL)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ------------------------------------------------------------------
	// Map behavior
	// ------------------------------------------------------------------

	// Xor-shift, multiply, xor-shift, then the magnitude of the signed
	// word; a word of 0x80000000 stays 0x80000000 as an unsigned value.
	function automatic int bucket_index(logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] s;
		logic [KEY_W-1:0] t;
		s = $signed(k) >>> 16;
		t = (s ^ k) * HASH_MULT;
		t = (t >> 16) ^ t;
		if (t[KEY_W-1])
			t = -t;
		return int'(t % 32'(NB));
	endfunction

	// A link is followed only if it names an allocated slot.
	function automatic bit link_ok(int unsigned p);
		return p < used_entries && p < POOL;
	endfunction

	// Walk one chain; -1 when the key is absent.
	function automatic int find_entry(int b, logic [KEY_W-1:0] k);
		int unsigned p;
		int          steps;
		p     = 32'(head_mem[b]);
		steps = 0;
		while (link_ok(p) && steps < POOL) begin
			if (key_mem[p] == k)
				return int'(p);
			p = 32'(next_mem[p]);
			steps++;
		end
		return -1;
	endfunction

	task automatic clear_table();
		for (int i = 0; i < NB; i++) begin
			head_mem[i] = NULL_LINK;
			tail_mem[i] = NULL_LINK;
		end
		for (int i = 0; i < POOL; i++) begin
			key_mem[i]  = '0;
			val_mem[i]  = '0;
			next_mem[i] = '0;
		end
		used_entries = 0;
	endtask

	// Append one predicted reply at the back of the pending list.
	task automatic queue_reply(cht_out_t r);
		table_replies.insert(table_replies.size(), r);
	endtask

	// Apply one accepted item to the shadow map and queue the replies it
	// must produce.
	task automatic hash_table_step(cht_in_t op);
		int          b;
		int          p;
		int unsigned q;
		int          listed;
		bit          have_prev;
		cht_out_t    r;
		cht_out_t    prev;
		r      = '0;
		r.last = 1'b1;
		case (op.mode)
			MODE_PUT: begin
				b = bucket_index(op.key);
				p = find_entry(b, op.key);
				if (p >= 0) begin
					// Existing key: overwrite the value in place.
					val_mem[p] = op.value;
					r.found    = 1'b1;
				end else if (used_entries >= POOL) begin
					r.status = STAT_FULL;
				end else begin
					// New key: take the next free slot, append to the chain.
					key_mem[used_entries]  = op.key;
					val_mem[used_entries]  = op.value;
					next_mem[used_entries] = NULL_LINK;
					if (link_ok(32'(tail_mem[b])) && link_ok(32'(head_mem[b])))
						next_mem[tail_mem[b]] = LINK_W'(used_entries);
					else
						head_mem[b] = LINK_W'(used_entries);
					tail_mem[b] = LINK_W'(used_entries);
					used_entries++;
				end
				r.entry_total = TOTAL_W'(used_entries);
				queue_reply(r);
			end
			MODE_GET: begin
				p = find_entry(bucket_index(op.key), op.key);
				if (p >= 0) begin
					r.found        = 1'b1;
					r.result_value = val_mem[p];
				end else begin
					r.status = STAT_MISS;
				end
				r.entry_total = TOTAL_W'(used_entries);
				queue_reply(r);
			end
			MODE_LIST: begin
				// Buckets in order, chain order inside each; mark the final key.
				listed    = 0;
				have_prev = 1'b0;
				prev      = '0;
				for (int bi = 0; bi < NB; bi++) begin
					q = 32'(head_mem[bi]);
					while (link_ok(q) && listed < POOL) begin
						if (have_prev)
							queue_reply(prev);
						prev             = '0;
						prev.result_key  = key_mem[q];
						prev.entry_total = TOTAL_W'(used_entries);
						have_prev        = 1'b1;
						listed++;
						q = 32'(next_mem[q]);
					end
				end
				if (have_prev) begin
					prev.last = 1'b1;
					queue_reply(prev);
				end else begin
					r.status      = STAT_MISS;
					r.entry_total = TOTAL_W'(used_entries);
					queue_reply(r);
				end
			end
			default: begin
				// Unused mode: consumed, nothing comes back.
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic check_result(cht_out_t got);
		cht_out_t want;
		if (table_replies.size() == 0) begin
			note_mismatch($sformatf("result with nothing pending: key %h status %0d",
				got.result_key, got.status));
			return;
		end
		want = table_replies.pop_front();
		if (got.status !== want.status)
			note_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
		if (got.found !== want.found)
			note_mismatch($sformatf("found %0d, predicted %0d", got.found, want.found));
		if (got.result_value !== want.result_value)
			note_mismatch($sformatf("result_value %h, predicted %h",
				got.result_value, want.result_value));
		if (got.result_key !== want.result_key)
			note_mismatch($sformatf("result_key %h, predicted %h",
				got.result_key, want.result_key));
		if (got.entry_total !== want.entry_total)
			note_mismatch($sformatf("entry_total %0d, predicted %0d",
				got.entry_total, want.entry_total));
		if (got.last !== want.last)
			note_mismatch($sformatf("last %0d, predicted %0d", got.last, want.last));
	endtask

	// ------------------------------------------------------------------
	// Driver: present queued items, idle in bursts, honor drain requests
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			gap_left   <= 0;
			tx_stretch <= 0;
			tx_noisy   <= 1'b1;
			calm_run   <= 1'b0;
			clear_table();
		end else begin
			// Predict on acceptance, from the payload that was on the wires.
			if (in_valid && in_ready)
				hash_table_step(in_item);

			if (in_valid && !in_ready) begin
				// Hold valid and payload until the unit takes the item.
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (op_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (op_queue[0].wait_drain && (in_valid || table_replies.size() != 0)) begin
				// Pause until every reply so far has been collected.
				in_valid <= 1'b0;
			end else if (!op_queue[0].calm && tx_noisy && $urandom_range(0, 3) == 0) begin
				// Start an idle gap with a random length drawn into gap_left, counting this one.
				gap_left <= $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else begin
				in_item  <= op_queue[0].op;
				in_valid <= 1'b1;
				calm_run <= op_queue[0].calm;
				op_queue.delete(0);
				// Alternate noisy and clean stretches of items.
				if (tx_stretch == 0) begin
					tx_stretch <= $urandom_range(4, 30);
					tx_noisy   <= 1'($urandom_range(0, 1));
				end else begin
					tx_stretch <= tx_stretch - 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: collect results, stall the output in bursts
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			rx_stretch <= 0;
			rx_noisy   <= 1'b1;
		end else begin
			if (out_valid && out_ready)
				check_result(out_item);

			if (rx_stretch == 0) begin
				rx_stretch <= $urandom_range(20, 200);
				rx_noisy   <= 1'($urandom_range(0, 1));
			end else begin
				rx_stretch <= rx_stretch - 1;
			end

			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else if (!calm_run && rx_noisy && $urandom_range(0, 4) == 0) begin
				stall_left <= $urandom_range(0, 16);
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic bit key_known(logic [KEY_W-1:0] k);
		foreach (gen_keys[i])
			if (gen_keys[i] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic add_op(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v, bit drain);
		queued_op_t e;
		e.op.mode   = m;
		e.op.key    = k;
		e.op.value  = v;
		e.wait_drain = drain;
		e.calm      = gen_calm;
		op_queue.insert(op_queue.size(), e);
	endtask

	// Track which keys will be stored so gets and updates can hit them.
	task automatic add_put(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		if (!key_known(k) && gen_keys.size() < POOL)
			gen_keys.insert(gen_keys.size(), k);
		add_op(MODE_PUT, k, v, 1'b0);
	endtask

	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = $urandom;
		while (key_known(k))
			k = $urandom;
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		if (gen_keys.size() == 0)
			return $urandom;
		return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
	endfunction

	// One random operation; put_new is the share of puts that add a key.
	task automatic add_random_op(int put_new);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if ($urandom_range(0, 99) < put_new)
				add_put(fresh_key(), $urandom);
			else
				add_put(stored_key(), $urandom);
		end else if (pick < 78) begin
			if ($urandom_range(0, 9) < 7)
				add_op(MODE_GET, stored_key(), $urandom, 1'b0);
			else
				add_op(MODE_GET, $urandom, $urandom, 1'b0);
		end else if (pick < 85) begin
			add_op(MODE_LIST, $urandom, $urandom, 1'b0);
		end else if (pick < 90) begin
			add_op(MODE_UNUSED, $urandom, $urandom, 1'b0);
		end else begin
			add_op(MODE_GET, fresh_key(), $urandom, 1'b0);
		end
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] chain_keys[$];
		logic [KEY_W-1:0] k;
		int               home;

		// Directed: empty table, extremes of key and value, update, miss.
		add_op(MODE_LIST, 32'h0, 32'h0, 1'b0);
		add_op(MODE_GET, 32'h0, 32'h0, 1'b0);
		add_op(MODE_UNUSED, 32'h1234_5678, 32'h9abc_def0, 1'b0);
		add_put(32'h8000_0000, 32'h7fff_ffff);
		add_put(32'h7fff_ffff, 32'h8000_0000);
		add_put(32'h0000_0000, 32'h0000_0000);
		add_put(32'hffff_ffff, 32'hffff_ffff);
		add_put(32'h0000_0001, 32'h0000_0001);
		add_op(MODE_GET, 32'h8000_0000, 32'h0, 1'b0);
		add_op(MODE_GET, 32'hffff_ffff, 32'h0, 1'b0);
		add_put(32'h8000_0000, 32'h0000_1234);
		add_op(MODE_GET, 32'h8000_0000, 32'hffff_ffff, 1'b0);
		add_op(MODE_GET, 32'h0000_0002, 32'h0, 1'b0);
		add_op(MODE_LIST, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
		add_op(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b0);

		// Directed: grow the chain that holds key zero, then hit its middle
		// and tail and miss past its end.
		home = bucket_index(32'h0);
		while (chain_keys.size() < 3) begin
			k = fresh_key();
			if (bucket_index(k) == home) begin
				chain_keys.insert(chain_keys.size(), k);
				add_put(k, $urandom);
			end
		end
		add_op(MODE_GET, chain_keys[1], 32'h0, 1'b0);
		add_op(MODE_GET, chain_keys[2], 32'h0, 1'b0);
		do
			k = fresh_key();
		while (bucket_index(k) != home);
		add_op(MODE_GET, k, 32'h0, 1'b0);
		add_op(MODE_LIST, 32'h0, 32'h0, 1'b0);

		// Random mix on a partly filled table.
		for (int i = 0; i < 140; i++)
			add_random_op(50);

		// Fill the pool, with lookups woven in.
		while (gen_keys.size() < POOL) begin
			add_put(fresh_key(), $urandom);
			if ($urandom_range(0, 3) == 0)
				add_op(MODE_GET, stored_key(), $urandom, 1'b0);
		end

		// Full table: list after a complete drain, rejected inserts, updates.
		add_op(MODE_LIST, $urandom, $urandom, 1'b1);
		for (int i = 0; i < 20; i++)
			add_random_op(60);

		// Closing stretch with no idling on either side.
		gen_calm = 1'b1;
		add_op(MODE_GET, stored_key(), $urandom, 1'b1);
		for (int i = 0; i < 13; i++)
			add_random_op(50);
		add_op(MODE_LIST, $urandom, $urandom, 1'b0);

		// Release reset away from the clock edge; the unit then runs its
		// clearing pass with in_ready low.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || in_valid || table_replies.size() != 0)
			@(negedge clk);
		// Watch for stray results after the last reply.
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
